// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- sv/bblur_pkg.sv -----
`default_nettype none

package bblur_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int DIM_W = 11;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = DIM_W;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(500);
    localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(2);

    // 9 * 255 plus rounding still fits
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 15;
    localparam int RECIP_SHIFT = 16;

    // ceil(2^16 / n); exact floor division for any sum below 2^15
    localparam logic [RECIP_W-1:0] RECIP_FOUR = RECIP_W'(16384);
    localparam logic [RECIP_W-1:0] RECIP_SIX  = RECIP_W'(10923);
    localparam logic [RECIP_W-1:0] RECIP_NINE = RECIP_W'(7282);

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pix_t;

    // Column entry of the line memory
    typedef struct packed {
        pix_t prev1;   // one row back
        pix_t prev2;   // two rows back
    } line_entry_t;

    // Which window rows/columns lie inside the image for one output
    typedef struct packed {
        logic top;
        logic bot;
        logic left;
        logic right;
        logic frame_end;
    } win_ctl_t;

    typedef enum logic [1:0] {
        CNT_FOUR,
        CNT_SIX,
        CNT_NINE
    } cnt_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] top);
        logic [DIM_W-1:0] res;
        if (v < DIM_MIN)
            res = DIM_MIN;
        else if (v > top)
            res = top;
        else
            res = v;
        return res;
    endfunction

    // Rounded mean: (sum + n/2) / n through a reciprocal multiply
    function automatic logic [7:0] div_round(input logic [SUM_W-1:0] sum, input cnt_t cnt);
        logic [SUM_W-1:0]         x;
        logic [RECIP_W-1:0]       m;
        logic [SUM_W+RECIP_W-1:0] p;
        case (cnt)
            CNT_FOUR:
            begin
                x = sum + SUM_W'(2);
                m = RECIP_FOUR;
            end
            CNT_SIX:
            begin
                x = sum + SUM_W'(3);
                m = RECIP_SIX;
            end
            CNT_NINE:
            begin
                x = sum + SUM_W'(4);
                m = RECIP_NINE;
            end
            default:
            begin
                x = sum + SUM_W'(2);
                m = RECIP_FOUR;
            end
        endcase
        p = (SUM_W+RECIP_W)'(x) * (SUM_W+RECIP_W)'(m);
        return p[RECIP_SHIFT +: 8];
    endfunction

endpackage

`default_nettype wire

// ----- sv/box_blur_3x3_rgb.sv -----
// Streaming 3x3 box blur of an RGB raster, one pixel per clock sustained while out_ready is
// high. Pixels enter in raster order; each output pixel is the rounded mean of its in-image
// 3x3 neighbours (nine, six on an edge, four at a corner), so outputs lag inputs by one row
// plus one pixel and W+1 flush transactions after the last pixel drain the frame. Two
// earlier rows live in one 1024 x 48-bit line memory, read at the incoming column and
// written back with the shifted rows when stage 1 advances; one read and one write per
// cycle set the rate. An output moves from stage 1 through stage 2, stage 3 and the output
// register. The configured width and height are clamped to 2..1024; writing either one
// restarts the frame position. The line memory needs no clearing after reset.
`default_nettype none

`include "assert_macros.svh"

module box_blur_3x3_rgb
    import bblur_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,

    input  wire logic             cfg_write,
    input  wire logic             cfg_index,
    input  wire logic [DIM_W-1:0] cfg_data,

    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       red_in,
    input  wire logic [7:0]       green_in,
    input  wire logic [7:0]       blue_in,
    input  wire logic             is_flush,

    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [7:0]            red_out,
    output logic [7:0]            green_out,
    output logic [7:0]            blue_out,
    output logic                  frame_end
);

    // Configuration and position
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;

    // Line memory
    line_entry_t      line_mem [0:MAX_WIDTH-1];
    line_entry_t      line_rd_reg;

    // Stage 1: read data returned, window update
    logic             s1_valid_reg;
    logic             s1_emit_reg;
    pix_t             s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    win_ctl_t         s1_ctl_reg;

    pix_t             window_reg [0:8];

    // Stage 2: window holds the neighbourhood of this output
    logic             s2_valid_reg;
    win_ctl_t         s2_ctl_reg;

    // Stage 3: channel sums
    logic             s3_valid_reg;
    logic [SUM_W-1:0] s3_sum_r_reg;
    logic [SUM_W-1:0] s3_sum_g_reg;
    logic [SUM_W-1:0] s3_sum_b_reg;
    cnt_t             s3_cnt_reg;
    logic             s3_end_reg;

    // Output register
    logic             out_valid_reg;
    pix_t             out_pix_reg;
    logic             out_end_reg;

    logic             accept;
    logic             out_load;
    logic             s3_free;
    logic             s3_adv;
    logic             s2_free;
    logic             s2_adv;
    logic             s1_adv;

    logic             col_zero;
    logic             col_last;
    logic             emit0;
    win_ctl_t         ctl0;
    pix_t             pix0;

    logic [2:0]       row_inc;
    logic [2:0]       col_inc;
    logic [SUM_W-1:0] sum_r;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_b;
    cnt_t             cnt2;

    // Handshake chain collapses bubbles: input flows while an output waits until stages fill
    assign out_load = !out_valid_reg || out_ready;
    assign s3_adv   = s3_valid_reg && out_load;
    assign s3_free  = !s3_valid_reg || out_load;
    assign s2_adv   = s2_valid_reg && s3_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    // Window must not move while stage 2 still reads it
    assign s1_adv   = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    // Position decode for the incoming transaction
    always_comb
    begin
        col_zero = (col_reg == '0);
        col_last = ((DIM_W'(col_reg) + DIM_W'(1)) == width_reg);
        if (col_zero)
        begin
            // right-edge pixel of row - 2, in the middle column of the post-shift window
            emit0          = (row_reg >= ROW_W'(2));
            ctl0.top       = (row_reg >= ROW_W'(3));
            ctl0.bot       = (row_reg <= height_reg);
            ctl0.left      = 1'b1;
            ctl0.right     = 1'b0;
            ctl0.frame_end = (row_reg == (height_reg + DIM_W'(1)));
        end
        else
        begin
            emit0          = (row_reg >= ROW_W'(1));
            ctl0.top       = (row_reg >= ROW_W'(2));
            ctl0.bot       = (row_reg < height_reg);
            ctl0.left      = (col_reg >= COL_W'(2));
            ctl0.right     = 1'b1;
            ctl0.frame_end = 1'b0;
        end
        pix0 = is_flush ? pix_t'(0) : pix_t'({red_in, green_in, blue_in});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_WIDTH)
                width_reg <= clamp_dim(cfg_data, DIM_W'(MAX_WIDTH));
            else
                height_reg <= clamp_dim(cfg_data, DIM_W'(MAX_HEIGHT));
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (emit0 && ctl0.frame_end)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (col_last)
            begin
                col_reg <= '0;
                row_reg <= row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // Within a frame, consecutive transactions hit different columns (width >= 2) and a column
    // is read again only after its write-back, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (accept)
            line_rd_reg <= line_mem[col_reg];
        if (s1_adv)
            line_mem[s1_col_reg] <= '{prev1: s1_pix_reg, prev2: line_rd_reg.prev1};
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= pix0;
            s1_col_reg  <= col_reg;
            s1_ctl_reg  <= ctl0;
            s1_emit_reg <= emit0;
        end
        if (s1_adv)
            s2_ctl_reg <= s1_ctl_reg;
        if (s2_adv)
        begin
            s3_sum_r_reg <= sum_r;
            s3_sum_g_reg <= sum_g;
            s3_sum_b_reg <= sum_b;
            s3_cnt_reg   <= cnt2;
            s3_end_reg   <= s2_ctl_reg.frame_end;
        end
        if (s3_adv)
        begin
            out_pix_reg.r <= div_round(s3_sum_r_reg, s3_cnt_reg);
            out_pix_reg.g <= div_round(s3_sum_g_reg, s3_cnt_reg);
            out_pix_reg.b <= div_round(s3_sum_b_reg, s3_cnt_reg);
            out_end_reg   <= s3_end_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 9; k++)
                window_reg[k] <= '0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
            begin
                window_reg[0] <= window_reg[1];
                window_reg[1] <= window_reg[2];
                window_reg[2] <= line_rd_reg.prev2;
                window_reg[3] <= window_reg[4];
                window_reg[4] <= window_reg[5];
                window_reg[5] <= line_rd_reg.prev1;
                window_reg[6] <= window_reg[7];
                window_reg[7] <= window_reg[8];
                window_reg[8] <= s1_pix_reg;
            end

            if (s1_adv && s1_emit_reg)
                s2_valid_reg <= 1'b1;
            else if (s2_adv)
                s2_valid_reg <= 1'b0;

            if (s2_adv)
                s3_valid_reg <= 1'b1;
            else if (s3_adv)
                s3_valid_reg <= 1'b0;

            if (s3_adv)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Masked sums over the post-shift window; the output pixel sits in its middle column,
    // right-edge pixels included.
    always_comb
    begin
        row_inc = {s2_ctl_reg.bot, 1'b1, s2_ctl_reg.top};
        col_inc = {s2_ctl_reg.right, 1'b1, s2_ctl_reg.left};
        sum_r   = '0;
        sum_g   = '0;
        sum_b   = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (row_inc[i] && col_inc[j])
                begin
                    sum_r = sum_r + SUM_W'(window_reg[i*3+j].r);
                    sum_g = sum_g + SUM_W'(window_reg[i*3+j].g);
                    sum_b = sum_b + SUM_W'(window_reg[i*3+j].b);
                end
            end
        end
        if (s2_ctl_reg.top && s2_ctl_reg.bot && s2_ctl_reg.left && s2_ctl_reg.right)
            cnt2 = CNT_NINE;
        else if ((s2_ctl_reg.top && s2_ctl_reg.bot) || (s2_ctl_reg.left && s2_ctl_reg.right))
            cnt2 = CNT_SIX;
        else
            cnt2 = CNT_FOUR;
    end

    assign out_valid = out_valid_reg;
    assign red_out   = out_pix_reg.r;
    assign green_out = out_pix_reg.g;
    assign blue_out  = out_pix_reg.b;
    assign frame_end = out_end_reg;

    `ASSERT_ALWAYS(a_col_in_row, DIM_W'(col_reg) < width_reg, "column beyond frame width")
    `ASSERT_ALWAYS(a_row_bound, row_reg <= (height_reg + DIM_W'(1)), "row past flush region")
    `ASSERT_IMPLY(a_window_cells, s2_valid_reg,
                  (s2_ctl_reg.left || s2_ctl_reg.right) && (s2_ctl_reg.top || s2_ctl_reg.bot),
                  "neighbourhood smaller than 2x2")

endmodule

`default_nettype wire
